### src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

### src/erpt_pkg.sv
package erpt_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int TRIG_ITERATIONS = 16;

    localparam int ANGLE_BITS  = 17;
    localparam int ANGLE_COUNT = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int FULL_TURN   = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int CORDIC_MAX  = 24;
    localparam int CORDIC_GAIN = 652032874;
    localparam int CORDIC_W    = 34;
    localparam int ZACC_W      = 33;
    localparam int ITER_W      = 5;
    localparam int TRIG_W      = 16;
    localparam int TERM_W      = 17;
    localparam int PROD_W      = TERM_W + COORD_WIDTH;
    localparam int ACC_W       = PROD_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

    typedef logic signed [ANGLE_BITS-1:0]  t_angle;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [TRIG_W-1:0]      t_trig;
    typedef logic signed [TERM_W-1:0]      t_term;

    typedef struct packed {
        t_coord in_x;
        t_coord in_y;
        t_coord in_z;
    } t_in_word;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        t_coord out_z;
        logic   clipped;
    } t_out_word;

    // row-major: m[row*3+col]
    typedef struct packed {
        t_term [8:0] m;
    } t_matrix;

    // CORDIC step angles, 2^-23 degree units
    function automatic logic signed [ZACC_W-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic signed [ZACC_W-1:0] v;
        case (i)
            5'd0:  v = 33'sd377487360;
            5'd1:  v = 33'sd222843801;
            5'd2:  v = 33'sd117744544;
            5'd3:  v = 33'sd59768969;
            5'd4:  v = 33'sd30000467;
            5'd5:  v = 33'sd15014858;
            5'd6:  v = 33'sd7509261;
            5'd7:  v = 33'sd3754860;
            5'd8:  v = 33'sd1877459;
            5'd9:  v = 33'sd938733;
            5'd10: v = 33'sd469367;
            5'd11: v = 33'sd234683;
            5'd12: v = 33'sd117342;
            5'd13: v = 33'sd58671;
            5'd14: v = 33'sd29335;
            5'd15: v = 33'sd14668;
            5'd16: v = 33'sd7334;
            5'd17: v = 33'sd3667;
            5'd18: v = 33'sd1833;
            5'd19: v = 33'sd917;
            5'd20: v = 33'sd458;
            5'd21: v = 33'sd229;
            5'd22: v = 33'sd115;
            5'd23: v = 33'sd57;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/erpt_setup.sv
module erpt_setup import erpt_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  t_angle [ANGLE_COUNT-1:0]    i_angles,
    output t_matrix                     o_matrix,
    output logic                        o_ready
);

    localparam logic [2:0] ST_RED  = 3'd0;
    localparam logic [2:0] ST_QUAD = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_MAT  = 3'd4;
    localparam logic [2:0] ST_LOAD = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [3:0] LAST_STEP = 4'd13;
    localparam logic [3:0] DRAIN_STEP = 4'd14;

    localparam logic signed [17:0] FULL = 18'(FULL_TURN);
    localparam logic signed [17:0] Q1   = 18'(QUARTER_TURN);
    localparam logic signed [17:0] Q2   = 18'(2 * QUARTER_TURN);
    localparam logic signed [17:0] Q3   = 18'(3 * QUARTER_TURN);
    localparam logic signed [CORDIC_W-16:0] TRIG_HI = 19'sd16384;
    localparam logic signed [CORDIC_W-16:0] TRIG_LO = -19'sd16384;

    logic [2:0]                 r_state, n_state;
    logic [1:0]                 r_idx;
    logic signed [17:0]         r_red;
    logic [1:0]                 r_quad;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ZACC_W-1:0]   r_z;
    logic [ITER_W-1:0]          r_iter;
    t_trig                      r_cos [ANGLE_COUNT];
    t_trig                      r_sin [ANGLE_COUNT];
    logic [3:0]                 r_step;
    t_trig                      r_prod [14];
    logic signed [2*TRIG_W-1:0] r_mul;
    logic                       r_mul_v;
    logic [3:0]                 r_mul_idx;
    t_matrix                    r_matrix;

    logic signed [17:0]         red_a, red_b;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [CORDIC_W:0]   x_rnd, y_rnd;
    logic signed [CORDIC_W-16:0] cq_w, sq_w;
    t_trig                      cq, sq, c_map, s_map;
    t_trig                      op_a, op_b;
    logic signed [2*TRIG_W:0]   mul_rnd;

    // angle wrap into one turn
    always_comb begin
        red_a = 18'(i_angles[r_idx]);
        if (red_a < 0) begin
            red_a = red_a + FULL;
        end else if (red_a >= FULL) begin
            red_a = red_a - FULL;
        end
        red_b = (red_a < 0) ? red_a + FULL : red_a;
    end

    assign dx = r_y >>> r_iter;
    assign dy = r_x >>> r_iter;

    // round Q1.30 to Q1.14 and clamp
    always_comb begin
        x_rnd = (CORDIC_W+1)'(r_x) + (CORDIC_W+1)'(32768);
        y_rnd = (CORDIC_W+1)'(r_y) + (CORDIC_W+1)'(32768);
        cq_w  = x_rnd[CORDIC_W:16];
        sq_w  = y_rnd[CORDIC_W:16];
        if (cq_w > TRIG_HI) cq_w = TRIG_HI;
        if (cq_w < TRIG_LO) cq_w = TRIG_LO;
        if (sq_w > TRIG_HI) sq_w = TRIG_HI;
        if (sq_w < TRIG_LO) sq_w = TRIG_LO;
        cq = TRIG_W'(cq_w);
        sq = TRIG_W'(sq_w);
        case (r_quad)
            2'd0:    begin c_map = cq;  s_map = sq;  end
            2'd1:    begin c_map = -sq; s_map = cq;  end
            2'd2:    begin c_map = -cq; s_map = -sq; end
            default: begin c_map = sq;  s_map = -cq; end
        endcase
    end

    // product schedule; 0 and 1 are sA*sB and cA*sB
    always_comb begin
        unique case (r_step)
            4'd0:    begin op_a = r_sin[0];  op_b = r_sin[1]; end
            4'd1:    begin op_a = r_cos[0];  op_b = r_sin[1]; end
            4'd2:    begin op_a = r_cos[1];  op_b = r_cos[2]; end
            4'd3:    begin op_a = r_cos[1];  op_b = r_sin[2]; end
            4'd4:    begin op_a = r_prod[0]; op_b = r_cos[2]; end
            4'd5:    begin op_a = r_cos[0];  op_b = r_sin[2]; end
            4'd6:    begin op_a = r_prod[0]; op_b = r_sin[2]; end
            4'd7:    begin op_a = r_cos[0];  op_b = r_cos[2]; end
            4'd8:    begin op_a = r_sin[0];  op_b = r_cos[1]; end
            4'd9:    begin op_a = r_prod[1]; op_b = r_cos[2]; end
            4'd10:   begin op_a = r_sin[0];  op_b = r_sin[2]; end
            4'd11:   begin op_a = r_prod[1]; op_b = r_sin[2]; end
            4'd12:   begin op_a = r_sin[0];  op_b = r_cos[2]; end
            4'd13:   begin op_a = r_cos[0];  op_b = r_cos[1]; end
            default: begin op_a = '0;        op_b = '0;       end
        endcase
    end

    assign mul_rnd = (2*TRIG_W+1)'(r_mul) + (2*TRIG_W+1)'(8192);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RED:  n_state = ST_QUAD;
            ST_QUAD: n_state = ST_ROT;
            ST_ROT:  if (r_iter == ITER_W'(TRIG_ITERATIONS - 1)) n_state = ST_FIN;
            ST_FIN:  n_state = (r_idx == 2'(ANGLE_COUNT - 1)) ? ST_MAT : ST_RED;
            ST_MAT:  if (r_step == DRAIN_STEP) n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DONE;
            ST_DONE: n_state = ST_DONE;
            default: n_state = ST_RED;
        endcase
        if (i_start) n_state = ST_RED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RED;
            r_idx   <= '0;
            r_iter  <= '0;
            r_step  <= '0;
            r_mul_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mul_v <= 1'b0;
            if (i_start) begin
                r_idx <= '0;
            end else begin
                unique case (r_state)
                    ST_QUAD: r_iter <= '0;
                    ST_ROT:  r_iter <= r_iter + 1'b1;
                    ST_FIN: begin
                        if (r_idx != 2'(ANGLE_COUNT - 1)) r_idx <= r_idx + 1'b1;
                        r_step <= '0;
                    end
                    ST_MAT: begin
                        if (r_step != DRAIN_STEP) r_step <= r_step + 1'b1;
                        r_mul_v <= (r_step <= LAST_STEP);
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_RED: r_red <= red_b;
            ST_QUAD: begin
                if (r_red >= Q3) begin
                    r_quad <= 2'd3;
                    r_z    <= ZACC_W'(r_red - Q3) <<< 16;
                end else if (r_red >= Q2) begin
                    r_quad <= 2'd2;
                    r_z    <= ZACC_W'(r_red - Q2) <<< 16;
                end else if (r_red >= Q1) begin
                    r_quad <= 2'd1;
                    r_z    <= ZACC_W'(r_red - Q1) <<< 16;
                end else begin
                    r_quad <= 2'd0;
                    r_z    <= ZACC_W'(r_red) <<< 16;
                end
                r_x <= CORDIC_W'(CORDIC_GAIN);
                r_y <= '0;
            end
            ST_ROT: begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_step(r_iter);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_step(r_iter);
                end
            end
            ST_FIN: begin
                r_cos[r_idx] <= c_map;
                r_sin[r_idx] <= s_map;
            end
            ST_MAT: begin
                r_mul     <= op_a * op_b;
                r_mul_idx <= r_step;
            end
            ST_LOAD: begin
                r_matrix.m[0] <= TERM_W'(r_prod[2]);
                r_matrix.m[1] <= -TERM_W'(r_prod[3]);
                r_matrix.m[2] <= TERM_W'(r_sin[1]);
                r_matrix.m[3] <= TERM_W'(r_prod[4]) + TERM_W'(r_prod[5]);
                r_matrix.m[4] <= TERM_W'(r_prod[7]) - TERM_W'(r_prod[6]);
                r_matrix.m[5] <= -TERM_W'(r_prod[8]);
                r_matrix.m[6] <= TERM_W'(r_prod[10]) - TERM_W'(r_prod[9]);
                r_matrix.m[7] <= TERM_W'(r_prod[11]) + TERM_W'(r_prod[12]);
                r_matrix.m[8] <= TERM_W'(r_prod[13]);
            end
            default: ;
        endcase
        if (r_mul_v) r_prod[r_mul_idx] <= mul_rnd[TRIG_W+13:14];
    end

    assign o_matrix = r_matrix;
    assign o_ready  = (r_state == ST_DONE) && !i_start;

endmodule

### src/erpt_mac.sv
module erpt_mac import erpt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_matrix   i_matrix,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    localparam int V_W = ACC_W - 14;
    localparam logic signed [V_W-1:0] HI = V_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [V_W-1:0] LO = -HI - V_W'(1);

    logic                       r_v1, r_v2, r_v3;
    logic signed [PROD_W-1:0]   r_p   [9];
    logic signed [ACC_W-1:0]    r_acc [3];
    t_out_word                  r_out;
    logic                       en;
    t_coord                     pt [3];
    logic signed [V_W-1:0]      v  [3];
    t_coord                     sat [3];
    logic [2:0]                 clip;

    assign en = !r_v3 || i_ready;
    assign pt[0] = i_word.in_x;
    assign pt[1] = i_word.in_y;
    assign pt[2] = i_word.in_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v[k] = r_acc[k][ACC_W-1:14];
            clip[k] = (v[k] > HI) || (v[k] < LO);
            if (v[k] > HI)      sat[k] = COORD_WIDTH'(HI);
            else if (v[k] < LO) sat[k] = COORD_WIDTH'(LO);
            else                sat[k] = COORD_WIDTH'(v[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_p[k] <= PROD_W'(i_matrix.m[k]) * PROD_W'(pt[k % 3]);
            end
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= ACC_W'(r_p[3*k]) + ACC_W'(r_p[3*k+1])
                          + ACC_W'(r_p[3*k+2]) + ACC_W'(8192);
            end
            r_out.out_x   <= sat[0];
            r_out.out_y   <= sat[1];
            r_out.out_z   <= sat[2];
            r_out.clipped <= |clip;
        end
    end

    assign o_ready = en;
    assign o_valid = r_v3;
    assign o_word  = r_out;

endmodule

### src/euler_rotation_point_transform.sv
// Rotates a stream of Q3.13 points by three Euler angles (1/128 degree units,
// X-Y-Z composition) held in configuration registers. After reset and after
// every configuration write the rotation matrix is rebuilt by a sequencer:
// for each angle a wrap step, a quadrant split, TRIG_ITERATIONS CORDIC
// iterations on one shared shift-add unit and a rounding step, then the
// matrix products through one shared 16x16 multiplier and a matrix load.
// o_in_ready is low during that rebuild. Afterwards one point word is taken
// per clock while the output side does not stall; each result passes the
// product, row sum and round/saturate registers, and the pipeline holds in
// place while the output side stalls.
`include "assert_macros.svh"

module euler_rotation_point_transform import erpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // point input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    // rotated point output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  t_angle                i_cfg_data
);

    t_angle [ANGLE_COUNT-1:0] r_angle;
    logic                     cfg_wr;
    t_matrix                  matrix;
    logic                     mat_ready;
    logic                     mac_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // angle registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_ANGLE_X: r_angle[0] <= i_cfg_data;
                REG_ANGLE_Y: r_angle[1] <= i_cfg_data;
                REG_ANGLE_Z: r_angle[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // any write restarts the matrix build
    erpt_setup u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cfg_wr),
        .i_angles (r_angle),
        .o_matrix (matrix),
        .o_ready  (mat_ready)
    );

    erpt_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_matrix (matrix),
        .i_valid  (i_in_valid && mat_ready),
        .o_ready  (mac_ready),
        .i_word   (i_in_word),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (o_out_word)
    );

    assign o_in_ready = mac_ready && mat_ready;

    // no point word enters on a stale matrix
    `ASSERT_IMPLIES(a_accept_needs_matrix, i_clk, i_rst_n, i_in_valid && o_in_ready, mat_ready)
    // a register write holds the input side off while the matrix rebuilds
    `ASSERT_NEXT(a_cfg_blocks_input, i_clk, i_rst_n, cfg_wr, !o_in_ready)

endmodule
